>>> hdl/encoder_homing_position_controller_macros.svh
// assertion macros for the encoder homing position controller
// sampled on clk, disabled while rst_n is low; empty bodies for synthesis
`ifndef ENCODER_HOMING_POSITION_CONTROLLER_MACROS_SVH
`define ENCODER_HOMING_POSITION_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS
// property holds at every clock edge out of reset
`define EHPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// consequent holds in the cycle after the trigger
`define EHPC_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);
`else
`define EHPC_ASSERT(lbl, prop, msg)
`define EHPC_ASSERT_NEXT(lbl, trig, cons, msg)
`endif

`endif

>>> hdl/ehpc_pkg.sv
// shared types and constants of the encoder homing position controller
// request and mode codes, servo codes, quadrature table, stream item layouts
package ehpc_pkg;

  // fixed field widths
  localparam int REQ_W      = 3;
  localparam int ARG_W      = 12;
  localparam int OFF_W      = 11;
  localparam int POS_W      = 11;
  localparam int PANEL_W    = 6;
  localparam int SERVO_W    = 8;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 48;

  // request kinds
  typedef enum logic [REQ_W-1:0] {
    REQ_SAMPLE     = 3'd0,
    REQ_TICK       = 3'd1,
    REQ_MOVE       = 3'd2,
    REQ_ADV_PANELS = 3'd3,
    REQ_ADV_PULSES = 3'd4,
    REQ_CALIBRATE  = 3'd5,
    REQ_STOP       = 3'd6,
    REQ_RESET      = 3'd7
  } req_t;

  // wheel modes
  typedef enum logic [2:0] {
    MODE_EMERGENCY = 3'd0,
    MODE_STOPPED   = 3'd1,
    MODE_AUTO_CAL  = 3'd2,
    MODE_CAL       = 3'd3,
    MODE_MOVING    = 3'd4,
    MODE_SLOW      = 3'd5
  } mode_t;

  // servo codes
  localparam logic [SERVO_W-1:0] SERVO_STOP = 8'd90;
  localparam logic [SERVO_W-1:0] SERVO_SLOW = 8'd97;
  localparam logic [SERVO_W-1:0] SERVO_NEAR = 8'd105;
  localparam logic [SERVO_W-1:0] SERVO_MID  = 8'd115;
  localparam logic [SERVO_W-1:0] SERVO_FAR  = 8'd125;
  localparam logic [SERVO_W-1:0] SERVO_FULL = 8'd140;
  localparam logic [SERVO_W-1:0] SERVO_SLOT = 8'd105;

  // quadrature decode, indexed by {prev a, prev b, a, b}
  localparam logic [15:0] QUAD_FWD = 16'h4182;
  localparam logic [15:0] QUAD_BWD = 16'h2814;

  // input transfer payload, lowest field last
  typedef struct packed {
    logic             pad;
    logic [ARG_W-1:0] argument;
    logic             optical_level;
    logic             enc_b;
    logic             enc_a;
  } in_item_t;

  // result transfer payload, lowest field last
  typedef struct packed {
    logic [5:0]         pad;
    logic               missed_steps;
    logic               fault;
    logic               is_calibrated;
    logic [POS_W-1:0]   goal_pulse;
    logic [PANEL_W-1:0] position_panel;
    logic [POS_W-1:0]   position_pulse;
    logic [SERVO_W-1:0] servo_code;
    logic [2:0]         mode_code;
  } out_item_t;

endpackage

>>> hdl/encoder_homing_position_controller.sv
// Encoder homing position controller: one result per input transfer.
// The result passes through the input register and then the result register.
// Throughput: one transfer per clock unless the result stream stalls; the state update sets that rate.
// in_tready drops only while both the input and result registers are full and stalled.
// Reset (rst_n low, synchronous): state, flags and the home offset cleared (previous optical level set high),
// mode stopped, servo code 90; no clearing pass.
`include "encoder_homing_position_controller_macros.svh"

module encoder_homing_position_controller
  import ehpc_pkg::*;
#(
  parameter int PANEL_COUNT   = 62,
  parameter int PANEL_PULSES  = 24,
  parameter int CENTER_OFFSET = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration: home pulse offset
  input  logic                  cfg_wr_en,
  input  logic [OFF_W-1:0]      cfg_wr_data,
  // request stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // enc_a, enc_b, optical_level, argument[11:0], 0
  input  logic [REQ_W-1:0]      in_tuser,   // req_type[2:0]
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // mode_code[2:0], servo_code[7:0],
                                            // position_pulse[10:0], position_panel[5:0],
                                            // goal_pulse[10:0], is_calibrated, fault,
                                            // missed_steps, 0
);

  // derived sizes
  localparam int PULSE_TOTAL = PANEL_COUNT * PANEL_PULSES;
  localparam int CW = $clog2(PULSE_TOTAL);
  localparam int PW = $clog2(PANEL_COUNT);
  localparam int SW = $clog2(PANEL_PULSES);
  localparam int APW = ARG_W + SW + 1;

  localparam logic [CW:0]   T_V        = (CW+1)'(PULSE_TOTAL);
  localparam logic [PW:0]   PC_V       = (PW+1)'(PANEL_COUNT);
  localparam logic [SW:0]   PPP_V      = (SW+1)'(PANEL_PULSES);
  localparam logic [CW-1:0] LAST_PULSE = CW'(PULSE_TOTAL - 1);
  localparam logic [SW-1:0] LAST_SUB   = SW'(PANEL_PULSES - 1);
  localparam logic [PW-1:0] LAST_PANEL = PW'(PANEL_COUNT - 1);
  localparam logic [CW-1:0] CO_MOD     = CW'(CENTER_OFFSET % PULSE_TOTAL);
  localparam logic [CW+1:0] REACH1     = (CW+2)'(PANEL_PULSES);
  localparam logic [CW+1:0] REACH2     = (CW+2)'(2 * PANEL_PULSES);
  localparam logic [CW+1:0] REACH3     = (CW+2)'(3 * PANEL_PULSES);
  localparam logic [ARG_W-1:0] ARG_PANEL_LIMIT = ARG_W'(PANEL_COUNT);

  // reciprocal constants, exact floor for the full input range
  localparam int S_ARG_PC = ARG_W + $clog2(PANEL_COUNT);
  localparam int S_ARG_T  = ARG_W + CW;
  localparam int S_OFF_PP = OFF_W + SW;
  localparam int S_OFF_T  = OFF_W + CW;
  localparam int M_ARG_PC = (2**S_ARG_PC + PANEL_COUNT - 1) / PANEL_COUNT;
  localparam int M_ARG_T  = (2**S_ARG_T + PULSE_TOTAL - 1) / PULSE_TOTAL;
  localparam int M_OFF_PP = (2**S_OFF_PP + PANEL_PULSES - 1) / PANEL_PULSES;
  localparam int M_OFF_T  = (2**S_OFF_T + PULSE_TOTAL - 1) / PULSE_TOTAL;

  // modular add of two values below the pulse count
  function automatic logic [CW-1:0] add_mod(input logic [CW-1:0] x, input logic [CW-1:0] y);
    logic [CW:0] s;
    s = {1'b0, x} + {1'b0, y};
    return (s >= T_V) ? CW'(s - T_V) : CW'(s);
  endfunction

  // handshake control
  logic s1_valid_r;
  logic out_valid_r;
  logic advance;
  logic fire;

  // input register
  req_t             s1_req_r;
  logic             s1_a_r;
  logic             s1_b_r;
  logic             s1_opt_r;
  logic [ARG_W-1:0] s1_arg_r;
  logic [ARG_W-1:0] s1_q_pc_r;
  logic [ARG_W-1:0] s1_q_t_r;

  // home offset and its quotients
  logic [OFF_W-1:0] off_r;
  logic [OFF_W-1:0] off_q_pp_r;
  logic [OFF_W-1:0] off_q_t_r;

  // wheel state
  logic [3:0]         hist_r,     hist_nxt;
  logic [CW-1:0]      raw_r,      raw_nxt;
  logic [SW-1:0]      sub_r,      sub_nxt;
  logic [PW-1:0]      panel_r,    panel_nxt;
  logic [CW-1:0]      goal_r,     goal_nxt;
  mode_t              mode_r,     mode_nxt;
  logic               cal_r,      cal_nxt;
  logic               fault_r,    fault_nxt;
  logic               warn_r,     warn_nxt;
  logic               opt_prev_r, opt_prev_nxt;
  logic [SERVO_W-1:0] servo_r,    servo_nxt;
  out_item_t          out_r,      out_nxt;

  in_item_t in_item;

  // quotients of the argument (at accept) and of the offset (at config write)
  logic [S_ARG_PC+ARG_W-1:0] arg_pc_prod;
  logic [S_ARG_T+ARG_W-1:0]  arg_t_prod;
  logic [S_OFF_PP+OFF_W-1:0] off_pp_prod;
  logic [S_OFF_T+OFF_W-1:0]  off_t_prod;

  // item datapath
  logic [3:0]    hist_cat;
  logic          is_sample;
  logic          fwd;
  logic          bwd;
  logic          home;
  logic          far_from_zero;
  logic [CW-1:0] raw_step;
  logic [SW-1:0] sub_step;
  logic [PW-1:0] panel_step;
  logic [CW-1:0] off_mod;
  logic [PW-1:0] off_panel;
  logic [SW-1:0] off_sub;
  logic [CW:0]   cur_sum;
  logic [CW-1:0] cur;
  logic [SW:0]   sub_sum;
  logic          sub_carry;
  logic [SW-1:0] cur_sub;
  logic [PW:0]   panel_sum;
  logic [PW-1:0] cur_panel;
  logic [CW-1:0] arg_mod_t;
  logic [APW-1:0] arg_ppp;
  logic [CW-1:0] adv_pulses;
  logic [CW-1:0] goal_move;
  logic [CW-1:0] goal_adv_panel;
  logic [CW-1:0] goal_adv_pulse;
  logic          reached;
  logic [CW-1:0] rem;
  mode_t         tick_mode;
  logic [SERVO_W-1:0] tick_code;
  logic [SERVO_W-1:0] tick_servo;

  // stream handshake: each stage moves when the one after it frees up
  assign advance    = !out_valid_r || out_tready;
  assign fire       = s1_valid_r && advance;
  assign in_tready  = !s1_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;
  assign in_item    = in_tdata;

  // reciprocal multiplies ahead of the registers
  assign arg_pc_prod = (S_ARG_PC+ARG_W)'(M_ARG_PC) * (S_ARG_PC+ARG_W)'(in_item.argument);
  assign arg_t_prod  = (S_ARG_T+ARG_W)'(M_ARG_T) * (S_ARG_T+ARG_W)'(in_item.argument);
  assign off_pp_prod = (S_OFF_PP+OFF_W)'(M_OFF_PP) * (S_OFF_PP+OFF_W)'(cfg_wr_data);
  assign off_t_prod  = (S_OFF_T+OFF_W)'(M_OFF_T) * (S_OFF_T+OFF_W)'(cfg_wr_data);

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_req_r  <= req_t'(in_tuser);
      s1_a_r    <= in_item.enc_a;
      s1_b_r    <= in_item.enc_b;
      s1_opt_r  <= in_item.optical_level;
      s1_arg_r  <= in_item.argument;
      s1_q_pc_r <= arg_pc_prod[S_ARG_PC +: ARG_W];
      s1_q_t_r  <= arg_t_prod[S_ARG_T +: ARG_W];
    end
  end

  // home offset register with quotients by panel size and pulse count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r      <= '0;
      off_q_pp_r <= '0;
      off_q_t_r  <= '0;
    end else if (cfg_wr_en) begin
      off_r      <= cfg_wr_data;
      off_q_pp_r <= off_pp_prod[S_OFF_PP +: OFF_W];
      off_q_t_r  <= off_t_prod[S_OFF_T +: OFF_W];
    end
  end

  // offset reduced modulo the wheel, split into panel and pulse within panel
  assign off_mod   = CW'(off_r - OFF_W'(off_q_t_r * T_V));
  assign off_panel = PW'(off_q_pp_r - OFF_W'(off_q_t_r * PC_V));
  assign off_sub   = SW'(off_r - OFF_W'(off_q_pp_r * PPP_V));

  // quadrature decode
  assign hist_cat  = {hist_r[1:0], s1_a_r, s1_b_r};
  assign is_sample = (s1_req_r == REQ_SAMPLE);
  assign fwd       = QUAD_FWD[hist_cat];
  assign bwd       = QUAD_BWD[hist_cat];
  assign home      = is_sample && fwd && !opt_prev_r && s1_opt_r;

  // counter step, kept both as a pulse count and as panel plus pulse
  always_comb begin
    raw_step   = raw_r;
    sub_step   = sub_r;
    panel_step = panel_r;
    if (fwd) begin
      raw_step = (raw_r == LAST_PULSE) ? '0 : raw_r + 1'b1;
      if (sub_r == LAST_SUB) begin
        sub_step   = '0;
        panel_step = (panel_r == LAST_PANEL) ? '0 : panel_r + 1'b1;
      end else begin
        sub_step = sub_r + 1'b1;
      end
    end else if (bwd) begin
      raw_step = (raw_r == '0) ? LAST_PULSE : raw_r - 1'b1;
      if (sub_r == '0) begin
        sub_step   = LAST_SUB;
        panel_step = (panel_r == '0) ? LAST_PANEL : panel_r - 1'b1;
      end else begin
        sub_step = sub_r - 1'b1;
      end
    end
  end

  assign far_from_zero = (raw_step != '0) && (raw_step != CW'(1)) && (raw_step != LAST_PULSE);

  // counter after this item
  always_comb begin
    raw_nxt   = raw_r;
    sub_nxt   = sub_r;
    panel_nxt = panel_r;
    if (home) begin
      raw_nxt   = '0;
      sub_nxt   = '0;
      panel_nxt = '0;
    end else if (is_sample) begin
      raw_nxt   = raw_step;
      sub_nxt   = sub_step;
      panel_nxt = panel_step;
    end
  end

  // current position with the home offset applied
  assign cur_sum   = {1'b0, raw_nxt} + {1'b0, off_mod};
  assign cur       = (cur_sum >= T_V) ? CW'(cur_sum - T_V) : CW'(cur_sum);
  assign sub_sum   = {1'b0, sub_nxt} + {1'b0, off_sub};
  assign sub_carry = (sub_sum >= PPP_V);
  assign cur_sub   = sub_carry ? SW'(sub_sum - PPP_V) : SW'(sub_sum);
  assign panel_sum = {1'b0, panel_nxt} + {1'b0, off_panel} + (PW+1)'(sub_carry);
  assign cur_panel = (panel_sum >= PC_V) ? PW'(panel_sum - PC_V) : PW'(panel_sum);

  // command targets
  assign arg_mod_t      = CW'(s1_arg_r - ARG_W'(s1_q_t_r * T_V));
  assign arg_ppp        = APW'(s1_arg_r) * APW'(PPP_V);
  assign adv_pulses     = CW'(arg_ppp - APW'(s1_q_pc_r) * APW'(T_V));
  assign goal_move      = add_mod(CW'(arg_ppp), CO_MOD);
  assign goal_adv_panel = add_mod(add_mod(cur - CW'(cur_sub), adv_pulses), CO_MOD);
  assign goal_adv_pulse = add_mod(cur, arg_mod_t);

  // forward distance to the goal
  assign reached = (cur == goal_r);
  assign rem     = (goal_r >= cur) ? goal_r - cur
                                   : CW'((CW+1)'(goal_r) + T_V - (CW+1)'(cur));

  // tick: mode transitions
  always_comb begin
    tick_mode = mode_r;
    case (mode_r)
      MODE_CAL: begin
        if (cal_r) tick_mode = MODE_STOPPED;
      end
      MODE_AUTO_CAL: begin
        if (cal_r) tick_mode = MODE_MOVING;
      end
      MODE_MOVING: begin
        if (!cal_r) tick_mode = MODE_AUTO_CAL;
        if (reached) tick_mode = MODE_STOPPED;
      end
      MODE_SLOW: begin
        if (reached) tick_mode = MODE_STOPPED;
      end
      default: begin
        tick_mode = mode_r;
      end
    endcase
  end

  // tick: servo code from the new mode, tapered by distance while moving
  always_comb begin
    case (tick_mode)
      MODE_AUTO_CAL, MODE_CAL: begin
        tick_code = s1_opt_r ? SERVO_FULL : SERVO_SLOT;
      end
      MODE_MOVING: begin
        if (rem == '0)                     tick_code = SERVO_STOP;
        else if ((CW+2)'(rem) <= REACH1)   tick_code = SERVO_NEAR;
        else if ((CW+2)'(rem) <= REACH2)   tick_code = SERVO_MID;
        else if ((CW+2)'(rem) <= REACH3)   tick_code = SERVO_FAR;
        else                               tick_code = SERVO_FULL;
      end
      MODE_SLOW: begin
        tick_code = SERVO_SLOW;
      end
      default: begin
        tick_code = SERVO_STOP;
      end
    endcase
  end

  assign tick_servo = fault_r ? SERVO_STOP : tick_code;

  // next state per request
  always_comb begin
    hist_nxt     = hist_r;
    goal_nxt     = goal_r;
    mode_nxt     = mode_r;
    cal_nxt      = cal_r;
    fault_nxt    = fault_r;
    warn_nxt     = warn_r;
    opt_prev_nxt = opt_prev_r;
    servo_nxt    = servo_r;
    case (s1_req_r)
      REQ_SAMPLE: begin
        hist_nxt = hist_cat;
        if (fwd) begin
          opt_prev_nxt = s1_opt_r;
          if (home) begin
            cal_nxt = 1'b1;
            if (cal_r && far_from_zero) warn_nxt = 1'b1;
          end
          if ((mode_r == MODE_MOVING || mode_r == MODE_SLOW) && reached) begin
            mode_nxt = MODE_STOPPED;
          end
        end
      end
      REQ_TICK: begin
        mode_nxt  = tick_mode;
        servo_nxt = tick_servo;
      end
      REQ_MOVE: begin
        if (s1_arg_r >= ARG_PANEL_LIMIT) begin
          servo_nxt = SERVO_STOP;
          fault_nxt = 1'b1;
          mode_nxt  = MODE_EMERGENCY;
        end else begin
          goal_nxt = goal_move;
          mode_nxt = MODE_MOVING;
        end
      end
      REQ_ADV_PANELS: begin
        goal_nxt = goal_adv_panel;
        mode_nxt = MODE_MOVING;
      end
      REQ_ADV_PULSES: begin
        goal_nxt = goal_adv_pulse;
        mode_nxt = MODE_SLOW;
      end
      REQ_CALIBRATE: begin
        cal_nxt  = 1'b0;
        goal_nxt = CO_MOD;
        mode_nxt = MODE_CAL;
      end
      REQ_STOP: begin
        servo_nxt = SERVO_STOP;
        mode_nxt  = MODE_STOPPED;
        goal_nxt  = cur;
      end
      REQ_RESET: begin
        servo_nxt = SERVO_STOP;
        mode_nxt  = MODE_STOPPED;
        cal_nxt   = 1'b0;
        fault_nxt = 1'b0;
        warn_nxt  = 1'b0;
      end
      default: begin
        mode_nxt = mode_r;
      end
    endcase
  end

  // result item
  always_comb begin
    out_nxt                = '0;
    out_nxt.mode_code      = 3'(mode_nxt);
    out_nxt.servo_code     = servo_nxt;
    out_nxt.position_pulse = POS_W'(cur);
    out_nxt.position_panel = PANEL_W'(cur_panel);
    out_nxt.goal_pulse     = POS_W'(goal_nxt);
    out_nxt.is_calibrated  = cal_nxt;
    out_nxt.fault          = fault_nxt;
    out_nxt.missed_steps   = warn_nxt;
  end

  // wheel state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r     <= '0;
      raw_r      <= '0;
      sub_r      <= '0;
      panel_r    <= '0;
      goal_r     <= '0;
      mode_r     <= MODE_STOPPED;
      cal_r      <= 1'b0;
      fault_r    <= 1'b0;
      warn_r     <= 1'b0;
      opt_prev_r <= 1'b1;
      servo_r    <= SERVO_STOP;
    end else if (fire) begin
      hist_r     <= hist_nxt;
      raw_r      <= raw_nxt;
      sub_r      <= sub_nxt;
      panel_r    <= panel_nxt;
      goal_r     <= goal_nxt;
      mode_r     <= mode_nxt;
      cal_r      <= cal_nxt;
      fault_r    <= fault_nxt;
      warn_r     <= warn_nxt;
      opt_prev_r <= opt_prev_nxt;
      servo_r    <= servo_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= out_nxt;
    end
  end

  // checks
  `EHPC_ASSERT(a_fault_holds_servo, out_tvalid && out_r.fault |-> out_r.servo_code == SERVO_STOP, "servo driven while faulted")
  `EHPC_ASSERT(a_emergency_faulted, out_tvalid && out_r.mode_code == MODE_EMERGENCY |-> out_r.fault, "emergency mode without fault")
  `EHPC_ASSERT(a_panel_matches_pulse, out_tvalid |-> (32'(out_r.position_panel) * PANEL_PULSES <= 32'(out_r.position_pulse)) && (32'(out_r.position_pulse) < (32'(out_r.position_panel) + 1) * PANEL_PULSES), "panel index disagrees with pulse position")
  `EHPC_ASSERT_NEXT(a_home_calibrates, fire && home, cal_r && raw_r == '0, "home edge did not zero and calibrate")

endmodule
